>>> rtl/lcpm_pkg.sv
// shared types and constants of the loop counter with per-loop mean power
`timescale 1ns / 1ps
`default_nettype none

package lcpm_pkg;

  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned POWER_W   = 32;
  localparam int unsigned LOOP_W    = 16;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned DIFF_W    = ANGLE_W + 1;
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // a quarter turn of the binary angle
  localparam logic signed [DIFF_W-1:0] QUARTER_TURN = DIFF_W'(16384);

  localparam logic signed [LOOP_W-1:0] LOOP_MAX = {1'b0, {(LOOP_W-1){1'b1}}};
  localparam logic signed [LOOP_W-1:0] LOOP_MIN = {1'b1, {(LOOP_W-1){1'b0}}};

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } lcpm_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;       // accept the input transaction and update the loop state
    logic div_start;  // launch the mean division on the finished loop
    logic mean_fin;   // load the quotient into the mean and the output register
  } lcpm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_need;   // current sample closes a loop that holds samples
    logic div_done;   // quotient ready
  } lcpm_sts_t;

endpackage

`default_nettype wire

>>> rtl/lcpm_if.sv
// valid/ready channel interfaces for the sample input and the result output
`timescale 1ns / 1ps
`default_nettype none

interface lcpm_in_if
  import lcpm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] lap_angle;
  logic signed [POWER_W-1:0] power_sample;
  logic                      crosswind_active;
  logic                      restart;

  modport source (
    output valid, lap_angle, power_sample, crosswind_active, restart,
    input  ready
  );
  modport sink (
    input  valid, lap_angle, power_sample, crosswind_active, restart,
    output ready
  );
endinterface

interface lcpm_out_if
  import lcpm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [LOOP_W-1:0]  lap_number;
  logic signed [POWER_W-1:0] mean_power_last_loop;

  modport source (
    output valid, lap_number, mean_power_last_loop,
    input  ready
  );
  modport sink (
    input  valid, lap_number, mean_power_last_loop,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/lcpm_div.sv
// serial restoring divider: signed 48-bit sum by unsigned 16-bit count
`timescale 1ns / 1ps
`default_nettype none

module lcpm_div
  import lcpm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SUM_W-1:0]   dividend_i,
  input  logic        [CNT_W-1:0]   divisor_i,
  output logic                      done_o,
  output logic signed [POWER_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W:0]    rem_q;
  logic [CNT_W-1:0]  den_q;

  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_nx;
  logic [SUM_W-1:0]  quo_nx;
  logic [SUM_W-1:0]  mag;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    quo_nx = {quo_q[SUM_W-2:0], ge};
    mag    = dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  end

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = STEP_W'(DIV_STEPS - 1);
    end else if (busy_q) begin
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      quo_q <= mag;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end
  end

  // sign restore, truncated toward zero
  assign quot_o = neg_q ? $signed(~quo_q[POWER_W-1:0] + 1'b1) : $signed(quo_q[POWER_W-1:0]);
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/lcpm_dp.sv
// datapath: angle difference, loop counter, power accumulation, mean and output register
`timescale 1ns / 1ps
`default_nettype none

module lcpm_dp
  import lcpm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES_PER_LOOP = 65535
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lcpm_cmd_t                 cmd_i,
  output lcpm_sts_t                 sts_o,
  input  logic signed [ANGLE_W-1:0] lap_angle_i,
  input  logic signed [POWER_W-1:0] power_sample_i,
  input  logic                      crosswind_active_i,
  input  logic                      restart_i,
  output logic signed [LOOP_W-1:0]  lap_number_o,
  output logic signed [POWER_W-1:0] mean_power_last_loop_o
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES_PER_LOOP);

  logic signed [ANGLE_W-1:0] prev_q;
  logic signed [LOOP_W-1:0]  loop_q, loop_d;
  logic        [CNT_W-1:0]   cnt_q, cnt_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic signed [POWER_W-1:0] mean_q, mean_d;
  logic signed [LOOP_W-1:0]  out_loop_q;
  logic signed [POWER_W-1:0] out_mean_q;

  logic signed [DIFF_W-1:0]  diff;
  logic                      crossing;
  logic                      cnt_zero;
  logic signed [SUM_W-1:0]   power_ext;
  logic                      div_done;
  logic signed [POWER_W-1:0] quot;

  // unwrapped angle step and loop crossing test
  always_comb begin
    diff      = $signed({lap_angle_i[ANGLE_W-1], lap_angle_i})
              - $signed({prev_q[ANGLE_W-1], prev_q});
    crossing  = !restart_i && crosswind_active_i
              && ((diff > QUARTER_TURN) || (diff < -QUARTER_TURN));
    cnt_zero  = (cnt_q == '0);
    power_ext = SUM_W'(power_sample_i);
  end

  // next loop state for an accepted transaction
  always_comb begin
    loop_d = loop_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    mean_d = mean_q;
    if (restart_i) begin
      loop_d = '0;
      mean_d = power_sample_i;
      sum_d  = power_ext;
      cnt_d  = CNT_W'(1);
    end else if (crossing) begin
      if (diff > 0) begin
        if (loop_q != LOOP_MAX) loop_d = loop_q + 1'b1;
      end else begin
        if (loop_q != LOOP_MIN) loop_d = loop_q - 1'b1;
      end
      if (cnt_zero) mean_d = '0;
      sum_d = power_ext;
      cnt_d = CNT_W'(1);
    end else if (cnt_q < CNT_MAX) begin
      sum_d = sum_q + power_ext;
      cnt_d = cnt_q + 1'b1;
    end
  end

  // loop state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      loop_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      mean_q <= '0;
    end else if (cmd_i.take) begin
      prev_q <= lap_angle_i;
      loop_q <= loop_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      mean_q <= mean_d;
    end else if (cmd_i.mean_fin) begin
      mean_q <= quot;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !cmd_i.div_start) begin
      out_loop_q <= loop_d;
      out_mean_q <= mean_d;
    end else if (cmd_i.mean_fin) begin
      out_loop_q <= loop_q;
      out_mean_q <= quot;
    end
  end

  // mean of the finished loop, from the old sum and count
  lcpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign sts_o.div_need       = crossing && !cnt_zero;
  assign sts_o.div_done       = div_done;
  assign lap_number_o         = out_loop_q;
  assign mean_power_last_loop_o = out_mean_q;

endmodule

`default_nettype wire

>>> rtl/lcpm_ctrl.sv
// controller: input acceptance, divide sequencing and output valid
`timescale 1ns / 1ps
`default_nettype none

module lcpm_ctrl
  import lcpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lcpm_cmd_t cmd_o,
  input  lcpm_sts_t sts_i
);

  lcpm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        load;

  // output slot is free when empty or being taken this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    load           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          cmd_o.take = 1'b1;
          if (sts_i.div_need) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end else begin
            load = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done && out_free) begin
          cmd_o.mean_fin = 1'b1;
          load           = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/loop_counter_with_per_loop_mean.sv
// top level of the loop counter with per-loop mean power
//
// Counts kite loops from successive 16-bit loop angles and reports with every sample the
// saturating loop number and the mean power of the last finished loop. A sample that does
// not close a loop, or closes one with no samples in it, gives its result in the cycle after
// acceptance and the next sample may follow in the next cycle. A sample that closes a
// nonempty loop starts a serial restoring divider that produces one quotient bit per cycle
// over the 48-bit power sum; no new sample is taken until its mean is loaded into the
// output register. A finished result waiting there does not hold up acceptance as long
// as the consumer takes it in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module loop_counter_with_per_loop_mean
  import lcpm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES_PER_LOOP = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lcpm_in_if.sink            in_i,
  lcpm_out_if.source         out_o
);

  lcpm_cmd_t cmd;
  lcpm_sts_t sts;

  // sequencing
  lcpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // loop state and arithmetic
  lcpm_dp #(
    .MAX_SAMPLES_PER_LOOP (MAX_SAMPLES_PER_LOOP)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .lap_angle_i            (in_i.lap_angle),
    .power_sample_i         (in_i.power_sample),
    .crosswind_active_i     (in_i.crosswind_active),
    .restart_i              (in_i.restart),
    .lap_number_o           (out_o.lap_number),
    .mean_power_last_loop_o (out_o.mean_power_last_loop)
  );

endmodule

`default_nettype wire

>>> rtl/lcpm_checker.sv
// port-level checker of the loop counter and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module lcpm_checker
  import lcpm_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic signed [POWER_W-1:0] power_sample_i,
  input logic                      crosswind_active_i,
  input logic                      restart_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [LOOP_W-1:0]  lap_number_i,
  input logic signed [POWER_W-1:0] mean_power_last_loop_i
);

  // a restart transaction answers next cycle with a cleared counter and its own power
  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && restart_i
    |=> out_valid_i && (lap_number_i == '0)
        && (mean_power_last_loop_i == $past(power_sample_i)))
    else $error("restart transaction did not give a reset result");

  // without crosswind no division is started, so the result goes straight to the output register
  a_no_crosswind_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !crosswind_active_i |=> out_valid_i)
    else $error("non-crossing transaction result late");

  // a stalled result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted while output register is stalled");

  // a stalled result holds its payload
  a_stall_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i
    |=> out_valid_i && $stable(lap_number_i) && $stable(mean_power_last_loop_i))
    else $error("stalled result changed");

endmodule

bind loop_counter_with_per_loop_mean lcpm_checker u_lcpm_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_valid_i             (in_i.valid),
  .in_ready_i             (in_i.ready),
  .power_sample_i         (in_i.power_sample),
  .crosswind_active_i     (in_i.crosswind_active),
  .restart_i              (in_i.restart),
  .out_valid_i            (out_o.valid),
  .out_ready_i            (out_o.ready),
  .lap_number_i           (out_o.lap_number),
  .mean_power_last_loop_i (out_o.mean_power_last_loop)
);

`default_nettype wire

>>> test/loop_counter_with_per_loop_mean_tb.sv
// self-checking testbench of the loop counter with per-loop mean power
`timescale 1ns / 1ps
`default_nettype none

module loop_counter_with_per_loop_mean_tb;
  import lcpm_pkg::*;

  localparam int unsigned SAMPLE_LIMIT  = 65535;
  localparam int unsigned RANDOM_TICKS  = 2000;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [POWER_W-1:0] power_t;
  typedef logic signed [LOOP_W-1:0]  loop_t;

  // one telemetry tick as queued for the driver
  typedef struct {
    angle_t      angle;
    power_t      power;
    logic        crosswind;
    logic        restart;
    int unsigned gap;
    bit          quiet;
  } telemetry_t;

  // one result transaction
  typedef struct {
    loop_t  lap_number;
    power_t mean_power;
  } loop_report_t;

  logic clk_i;
  logic rst_ni;

  lcpm_in_if  in_if ();
  lcpm_out_if out_if ();

  loop_counter_with_per_loop_mean #(
    .MAX_SAMPLES_PER_LOOP(SAMPLE_LIMIT)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  telemetry_t   pending_ticks[$];
  loop_report_t expected_reports[$];

  // loop tracker state, mirrors the block
  angle_t      last_angle    = '0;
  loop_t       laps_done     = '0;
  int unsigned loop_samples  = 0;
  longint      power_total   = 0;
  power_t      recorded_mean = '0;

  int unsigned mismatches = 0;

  // driver and sink bookkeeping
  telemetry_t  cur_tick;
  bit          feeding    = 1'b0;
  bit          in_taken   = 1'b0;
  bit          sink_quiet = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  // advance the loop tracker by one sample and return the report it gives
  function automatic loop_report_t track_sample(angle_t angle, power_t power,
                                                logic crosswind, logic restart);
    int           swing;
    int           swing_mag;
    longint       quotient;
    loop_report_t rep;
    if (restart) begin
      laps_done     = '0;
      loop_samples  = 0;
      power_total   = 0;
      last_angle    = angle;
      recorded_mean = power;
    end
    swing     = int'(angle) - int'(last_angle);
    swing_mag = (swing < 0) ? -swing : swing;
    if (swing_mag > QUARTER_TURN && crosswind) begin
      if (swing > 0) begin
        if (laps_done != LOOP_MAX) laps_done++;
      end else begin
        if (laps_done != LOOP_MIN) laps_done--;
      end
      if (loop_samples == 0) begin
        recorded_mean = '0;
      end else begin
        quotient      = power_total / longint'(loop_samples);
        recorded_mean = power_t'(quotient);
      end
      loop_samples = 0;
      power_total  = 0;
    end
    if (loop_samples < SAMPLE_LIMIT) begin
      power_total += longint'(power);
      loop_samples++;
    end
    last_angle       = angle;
    rep.lap_number   = laps_done;
    rep.mean_power   = recorded_mean;
    return rep;
  endfunction

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    return ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // power values weighted toward the extremes
  function automatic power_t pick_power();
    case ($urandom_range(7))
      0:       return {1'b1, {(POWER_W-1){1'b0}}};
      1:       return {1'b0, {(POWER_W-1){1'b1}}};
      2:       return power_t'(int'($urandom_range(200)) - 100);
      default: return power_t'($urandom());
    endcase
  endfunction

  function automatic void add_tick(angle_t angle, power_t power, logic crosswind,
                                   logic restart, int unsigned gap, bit quiet);
    telemetry_t t;
    t.angle     = angle;
    t.power     = power;
    t.crosswind = crosswind;
    t.restart   = restart;
    t.gap       = gap;
    t.quiet     = quiet;
    pending_ticks.push_back(t);
  endfunction

  function automatic void add_directed(int angle, power_t power, logic crosswind,
                                       logic restart);
    add_tick(angle_t'(angle), power, crosswind, restart,
             $urandom_range(1) ? 0 : idle_len(), 1'b0);
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("[loop_counter_with_per_loop_mean] ERROR");
    $finish;
  end

  // sample driver, one queued tick at a time
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (feeding && in_taken) feeding = 1'b0;
      in_taken = 1'b0;
      if (!feeding && pending_ticks.size() != 0) begin
        cur_tick   = pending_ticks.pop_front();
        gap_left   = cur_tick.gap;
        feeding    = 1'b1;
        sink_quiet <= cur_tick.quiet;
      end
      if (feeding && gap_left == 0) begin
        in_if.valid            <= 1'b1;
        in_if.lap_angle        <= cur_tick.angle;
        in_if.power_sample     <= cur_tick.power;
        in_if.crosswind_active <= cur_tick.crosswind;
        in_if.restart          <= cur_tick.restart;
      end else begin
        if (gap_left != 0) gap_left--;
        in_if.valid <= 1'b0;
      end
    end
  end

  // result sink with random backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left == 0 && !sink_quiet && $urandom_range(99) < 20) stall_left = idle_len();
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor: check result transactions, predict on sample transactions
  always @(posedge clk_i) begin
    loop_report_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: lap_number %0d mean_power_last_loop %0d",
                     out_if.lap_number, out_if.mean_power_last_loop);
        end else begin
          want = expected_reports.pop_front();
          if (out_if.lap_number !== want.lap_number ||
              out_if.mean_power_last_loop !== want.mean_power) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("mismatch: lap_number exp %0d got %0d, mean exp %0d got %0d",
                       want.lap_number, out_if.lap_number,
                       want.mean_power, out_if.mean_power_last_loop);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        expected_reports.push_back(track_sample(in_if.lap_angle, in_if.power_sample,
                                                in_if.crosswind_active, in_if.restart));
        in_taken = 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    angle_t      ang;
    power_t      pmax;
    power_t      pmin;
    int unsigned made;
    int unsigned seg_len;
    int unsigned mode;
    int unsigned stride;
    int          dir;
    bit          calm;
    logic        cw;
    logic        rs;

    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.lap_angle        = '0;
    in_if.power_sample     = '0;
    in_if.crosswind_active = 1'b0;
    in_if.restart          = 1'b0;
    out_if.ready           = 1'b0;

    pmax = {1'b0, {(POWER_W-1){1'b1}}};
    pmin = {1'b1, {(POWER_W-1){1'b0}}};

    // crossing right after reset closes an empty loop
    add_directed(20000, pmax, 1'b1, 1'b0);
    // exactly a quarter turn down is no crossing
    add_directed(3616, pmin, 1'b1, 1'b0);
    // just past a quarter turn, mean of -1 over 2 truncates to zero
    add_directed(-12769, 5, 1'b1, 1'b0);
    // large swing without crosswind
    add_directed(32767, 100, 1'b0, 1'b0);
    // full-scale swings both ways
    add_directed(-32768, -3, 1'b1, 1'b0);
    add_directed(32767, 7, 1'b1, 1'b0);
    add_directed(16383, 0, 1'b1, 1'b0);
    // restart across a large jump, then a negative mean that truncates toward zero
    add_directed(-20000, -7, 1'b1, 1'b1);
    add_directed(-19000, -2, 1'b1, 1'b0);
    add_directed(0, pmin, 1'b1, 1'b0);
    // loop of most negative samples
    add_directed(100, pmin, 1'b1, 1'b0);
    add_directed(200, pmin, 1'b1, 1'b0);
    add_directed(300, pmin, 1'b1, 1'b0);
    add_directed(-30000, 0, 1'b1, 1'b0);
    add_directed(-13615, pmax, 1'b1, 1'b0);
    // back-to-back restarts, with and without crosswind
    add_directed(500, 42, 1'b0, 1'b1);
    add_directed(501, 43, 1'b1, 1'b1);
    add_directed(-32768, 1, 1'b1, 1'b0);

    // random part: mostly steady looping, some quarter-turn probes and noise
    ang  = angle_t'(30000);
    made = 0;
    while (made < RANDOM_TICKS) begin
      seg_len = $urandom_range(4, 40);
      calm    = ($urandom_range(4) == 0);
      mode    = $urandom_range(9);
      dir     = $urandom_range(1) ? 1 : -1;
      stride  = $urandom_range(200, 15000);
      for (int k = 0; k < seg_len; k++) begin
        cw = 1'b1;
        rs = 1'b0;
        if (mode == 0) begin
          ang = angle_t'($urandom());
          cw  = 1'($urandom_range(1));
          rs  = ($urandom_range(7) == 0);
        end else if (mode == 1) begin
          ang = ang + angle_t'(($urandom_range(1) ? 1 : -1) *
                               (16383 + int'($urandom_range(2))));
          cw  = ($urandom_range(7) != 0);
        end else begin
          ang = ang + angle_t'(dir * int'($urandom_range(stride / 2, stride)));
          cw  = ($urandom_range(19) != 0);
          rs  = ($urandom_range(149) == 0);
        end
        add_tick(ang, pick_power(), cw, rs,
                 calm ? 0 : ($urandom_range(1) ? 0 : idle_len()), calm);
        made++;
      end
    end

    // reset
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait until every sample went in and every result came back
    while (pending_ticks.size() != 0 || feeding || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[loop_counter_with_per_loop_mean] OK");
    end else begin
      $display("[loop_counter_with_per_loop_mean] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/lcpm_pkg.sv
rtl/lcpm_if.sv
rtl/lcpm_div.sv
rtl/lcpm_dp.sv
rtl/lcpm_ctrl.sv
rtl/loop_counter_with_per_loop_mean.sv
rtl/lcpm_checker.sv
test/loop_counter_with_per_loop_mean_tb.sv
